/* sv/psaw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package psaw_pkg;

  // Field widths fixed by the interface definition.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LIMIT_W   = 2;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the output bounds.
  localparam logic signed [WORD_W-1:0] UPPER_RESET = 32'sd500000;
  localparam logic signed [WORD_W-1:0] LOWER_RESET = -32'sd500000;

  // Item operations.
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SEED   = 2'd2
  } op_e;

  // Clamp status reported with each result.
  typedef enum logic [LIMIT_W-1:0] {
    LIM_NONE  = 2'd0,
    LIM_UPPER = 2'd1,
    LIM_LOWER = 2'd2
  } limit_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 2'd0,
    REG_KI    = 2'd1,
    REG_UPPER = 2'd2,
    REG_LOWER = 2'd3
  } cfg_reg_e;

  // Payload leaving the multiplier stage.
  typedef struct packed {
    op_e                       op;
    logic signed [PROD_W-1:0]  p_term;
    logic signed [PROD_W-1:0]  i_term;
  } prod_t;

  // Payload leaving the servo update stage.
  typedef struct packed {
    logic signed [WORD_W-1:0]  scale;
    limit_e                    limit;
    logic signed [ACC_W-1:0]   acc;
  } upd_t;

endpackage

`default_nettype wire

/* sv/psaw_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sample item channel.
interface psaw_smp_if import psaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [WORD_W-1:0] ofs_ns;

  modport source (output valid, output op, output ofs_ns, input ready);
  modport sink   (input valid, input op, input ofs_ns, output ready);
endinterface

// Result item channel.
interface psaw_res_if import psaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] scale_ppb;
  logic [LIMIT_W-1:0]       limit_hit;
  logic signed [WORD_W-1:0] integral_ppb;

  modport source (output valid, output scale_ppb, output limit_hit, output integral_ppb,
                  input ready);
  modport sink   (input valid, input scale_ppb, input limit_hit, input integral_ppb,
                  output ready);
endinterface

// Configuration write channel.
interface psaw_cfg_if import psaw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/pi_clock_servo_antiwindup_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// PI clock-rate servo with anti-windup.
//
// Channels: cfg_i writes the gains (kp, ki, with GAIN_FRAC_BITS fraction bits) and
// the scale bounds in ppb; it is always ready and should only be written while no
// item is in flight. smp_i takes one item per handshake: a sample offset in ns, an
// integral clear, or an integral seed from the last scale. res_o returns exactly
// one item per accepted item, in order: clamped scale, clamp status and integral.
//
// Pipeline: four register stages (input, gain products, servo update, result); an
// accepted item passes through them in that order. Throughput is one item per cycle
// while res_o is ready; the servo state is updated in a single stage, so consecutive
// items see each other's updates without waiting.
//
// Reset clears the integral and the last scale, sets the gains to zero and the
// bounds to +/-500000 ppb, and empties the pipeline. When res_o stalls, the result
// register holds its item and each earlier stage keeps accepting until it is full,
// so up to four items are held before smp_i drops ready.
module pi_clock_servo_antiwindup_unit import psaw_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psaw_cfg_if.sink   cfg_i,
  psaw_smp_if.sink   smp_i,
  psaw_res_if.source res_o
);

  logic [WORD_W-1:0]        kp_q;
  logic [WORD_W-1:0]        ki_q;
  logic signed [WORD_W-1:0] upper_q;
  logic signed [WORD_W-1:0] lower_q;

  logic                     in_valid_q;
  op_e                      in_op_q;
  logic signed [WORD_W-1:0] in_offset_q;
  logic                     in_load;

  logic                     mult_ready;
  logic                     prod_valid;
  prod_t                    prod;
  logic                     core_ready;
  logic                     upd_valid;
  upd_t                     upd;
  logic                     out_ready;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      upper_q <= UPPER_RESET;
      lower_q <= LOWER_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_KP:    kp_q    <= cfg_i.data;
        REG_KI:    ki_q    <= cfg_i.data;
        REG_UPPER: upper_q <= cfg_i.data;
        REG_LOWER: lower_q <= cfg_i.data;
      endcase
    end
  end

  // Input register.
  assign smp_i.ready = !in_valid_q || mult_ready;
  assign in_load     = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (smp_i.ready) begin
      in_valid_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q     <= op_e'(smp_i.op);
      in_offset_q <= smp_i.ofs_ns;
    end
  end

  psaw_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kp_gain_i   (kp_q),
    .ki_gain_i   (ki_q),
    .up_valid_i  (in_valid_q),
    .up_ready_o  (mult_ready),
    .up_op_i     (in_op_q),
    .up_offset_i (in_offset_q),
    .dn_valid_o  (prod_valid),
    .dn_ready_i  (core_ready),
    .dn_o        (prod)
  );

  psaw_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upper_i    (upper_q),
    .lower_i    (lower_q),
    .up_valid_i (prod_valid),
    .up_ready_o (core_ready),
    .up_i       (prod),
    .dn_valid_o (upd_valid),
    .dn_ready_i (out_ready),
    .dn_o       (upd)
  );

  psaw_out #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (upd_valid),
    .up_ready_o (out_ready),
    .up_i       (upd),
    .valid_o    (res_o.valid),
    .ready_i    (res_o.ready),
    .scale_o    (res_o.scale_ppb),
    .limit_o    (res_o.limit_hit),
    .integral_o (res_o.integral_ppb)
  );

endmodule

`default_nettype wire

/* sv/psaw_mult.sv */
`timescale 1ns / 1ps
`default_nettype none

// Gain multiplier stage: forms both gain products of the offset and registers them.
module psaw_mult import psaw_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [WORD_W-1:0]        kp_gain_i,
  input  wire logic [WORD_W-1:0]        ki_gain_i,
  input  wire logic                     up_valid_i,
  output logic                          up_ready_o,
  input  wire op_e                      up_op_i,
  input  wire logic signed [WORD_W-1:0] up_offset_i,
  output logic                          dn_valid_o,
  input  wire logic                     dn_ready_i,
  output prod_t                         dn_o
);

  logic                    valid_q;
  prod_t                   prod_q;
  prod_t                   prod_d;
  logic signed [PROD_W:0]  p_full;
  logic signed [PROD_W:0]  i_full;
  logic                    load;

  // The gains are unsigned, so each gets a zero sign bit before the signed multiply.
  assign p_full = $signed({1'b0, kp_gain_i}) * up_offset_i;
  assign i_full = $signed({1'b0, ki_gain_i}) * up_offset_i;

  always_comb begin
    prod_d.op     = up_op_i;
    prod_d.p_term = p_full[PROD_W-1:0];
    prod_d.i_term = i_full[PROD_W-1:0];
  end

  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;

  // Stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q <= prod_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_o       = prod_q;

endmodule

`default_nettype wire

/* sv/psaw_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Servo update stage: sums the terms with the integral, truncates and clamps the
// result, and updates the integral and the last scale.
module psaw_core import psaw_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [WORD_W-1:0] upper_i,
  input  wire logic signed [WORD_W-1:0] lower_i,
  input  wire logic                     up_valid_i,
  output logic                          up_ready_o,
  input  wire prod_t                    up_i,
  output logic                          dn_valid_o,
  input  wire logic                     dn_ready_i,
  output upd_t                          dn_o
);

  // Three 64-bit terms need two guard bits.
  localparam int unsigned SUM_W = ACC_W + 2;
  localparam int unsigned Q_W   = SUM_W - GAIN_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic                     valid_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [WORD_W-1:0] last_q;
  logic signed [WORD_W-1:0] last_d;
  limit_e                   limit_q;
  limit_e                   limit_d;
  logic                     load;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_shr;
  logic                     sum_round;
  logic signed [Q_W-1:0]    q_whole;
  logic signed [Q_W-1:0]    upper_ext;
  logic signed [Q_W-1:0]    lower_ext;
  logic                     over;
  logic                     under;
  logic signed [ACC_W:0]    acc_add;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W-1:0]  acc_seed;

  // Exact sum of both terms and the integral.
  assign sum = {{2{up_i.p_term[PROD_W-1]}}, up_i.p_term}
             + {{2{up_i.i_term[PROD_W-1]}}, up_i.i_term}
             + {{2{acc_q[ACC_W-1]}}, acc_q};

  // Truncate toward zero: the arithmetic shift floors, so a negative value with a
  // nonzero fraction moves up by one.
  assign sum_shr   = sum >>> GAIN_FRAC_BITS;
  assign sum_round = sum[SUM_W-1] && (|sum[GAIN_FRAC_BITS-1:0]);
  assign q_whole   = sum_shr[Q_W-1:0] + Q_W'(sum_round);

  // The whole sum is wide enough that an out-of-range total still clamps on its sign.
  assign upper_ext = {{(Q_W-WORD_W){upper_i[WORD_W-1]}}, upper_i};
  assign lower_ext = {{(Q_W-WORD_W){lower_i[WORD_W-1]}}, lower_i};
  assign over      = q_whole > upper_ext;
  assign under     = q_whole < lower_ext;

  // Integral plus the new integral term, saturated at the accumulator limits.
  assign acc_add = {acc_q[ACC_W-1], acc_q} + {up_i.i_term[PROD_W-1], up_i.i_term};
  always_comb begin
    if (acc_add[ACC_W] != acc_add[ACC_W-1]) begin
      acc_sat = acc_add[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_add[ACC_W-1:0];
    end
  end

  // Seeding loads the last scale as a whole number of ppb.
  assign acc_seed = {{(ACC_W-WORD_W-GAIN_FRAC_BITS){last_q[WORD_W-1]}}, last_q,
                     {GAIN_FRAC_BITS{1'b0}}};

  // Next state for one item. The upper test takes precedence over the lower one.
  always_comb begin
    acc_d   = acc_q;
    last_d  = last_q;
    limit_d = LIM_NONE;
    unique case (up_i.op)
      OP_SAMPLE: begin
        priority if (over) begin
          last_d  = upper_i;
          limit_d = LIM_UPPER;
        end else if (under) begin
          last_d  = lower_i;
          limit_d = LIM_LOWER;
        end else begin
          last_d = q_whole[WORD_W-1:0];
          acc_d  = acc_sat;
        end
      end
      OP_CLEAR: begin
        acc_d = '0;
      end
      OP_SEED: begin
        acc_d = acc_seed;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;

  // Servo state and stage occupancy. The state changes once per item, as it enters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= '0;
      last_q  <= '0;
      limit_q <= LIM_NONE;
    end else begin
      if (up_ready_o) begin
        valid_q <= up_valid_i;
      end
      if (load) begin
        acc_q   <= acc_d;
        last_q  <= last_d;
        limit_q <= limit_d;
      end
    end
  end

  // The state registers hold exactly what the item in this stage left behind.
  always_comb begin
    dn_o.scale = last_q;
    dn_o.limit = limit_q;
    dn_o.acc   = acc_q;
  end

  assign dn_valid_o = valid_q;

endmodule

`default_nettype wire

/* sv/psaw_out.sv */
`timescale 1ns / 1ps
`default_nettype none

// Result stage: reduces the integral to whole ppb and holds the result item.
module psaw_out import psaw_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 up_valid_i,
  output logic                      up_ready_o,
  input  wire upd_t                 up_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic signed [WORD_W-1:0]  scale_o,
  output logic [LIMIT_W-1:0]        limit_o,
  output logic signed [WORD_W-1:0]  integral_o
);

  localparam int unsigned I_W = ACC_W - GAIN_FRAC_BITS;

  localparam logic signed [I_W-1:0] I32_MAX = {{(I_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [I_W-1:0] I32_MIN = {{(I_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  logic                     valid_q;
  logic signed [WORD_W-1:0] scale_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic signed [WORD_W-1:0] integral_q;
  logic signed [WORD_W-1:0] integral_d;
  logic signed [ACC_W-1:0]  acc_shr;
  logic                     acc_round;
  logic signed [I_W-1:0]    acc_whole;
  logic                     load;

  // Truncate the integral toward zero, then saturate it to a 32-bit word.
  assign acc_shr   = up_i.acc >>> GAIN_FRAC_BITS;
  assign acc_round = up_i.acc[ACC_W-1] && (|up_i.acc[GAIN_FRAC_BITS-1:0]);
  assign acc_whole = acc_shr[I_W-1:0] + I_W'(acc_round);

  always_comb begin
    if (acc_whole > I32_MAX) begin
      integral_d = I32_MAX[WORD_W-1:0];
    end else if (acc_whole < I32_MIN) begin
      integral_d = I32_MIN[WORD_W-1:0];
    end else begin
      integral_d = acc_whole[WORD_W-1:0];
    end
  end

  assign up_ready_o = !valid_q || ready_i;
  assign load       = up_valid_i && up_ready_o;

  // Result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      scale_q    <= up_i.scale;
      limit_q    <= up_i.limit;
      integral_q <= integral_d;
    end
  end

  assign valid_o    = valid_q;
  assign scale_o    = scale_q;
  assign limit_o    = limit_q;
  assign integral_o = integral_q;

endmodule

`default_nettype wire

/* sv/psaw_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the servo unit.
module psaw_chk import psaw_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     cfg_valid,
  input wire logic                     cfg_ready,
  input wire logic [CFG_IDX_W-1:0]     cfg_index,
  input wire logic [WORD_W-1:0]        cfg_data,
  input wire logic                     smp_valid,
  input wire logic                     smp_ready,
  input wire logic                     res_valid,
  input wire logic                     res_ready,
  input wire logic signed [WORD_W-1:0] res_scale,
  input wire logic [LIMIT_W-1:0]       res_limit,
  input wire logic signed [WORD_W-1:0] res_integral
);

  logic signed [WORD_W-1:0] upper_q;
  logic signed [WORD_W-1:0] lower_q;
  logic [2:0]               inflight_q;
  logic                     smp_acc;
  logic                     res_acc;

  assign smp_acc = smp_valid && smp_ready;
  assign res_acc = res_valid && res_ready;

  // Shadow copies of the bounds and a count of items in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q    <= UPPER_RESET;
      lower_q    <= LOWER_RESET;
      inflight_q <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == REG_UPPER) begin
        upper_q <= cfg_data;
      end
      if (cfg_valid && cfg_ready && cfg_index == REG_LOWER) begin
        lower_q <= cfg_data;
      end
      inflight_q <= inflight_q + 3'(smp_acc) - 3'(res_acc);
    end
  end

  // A stalled result holds its value.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_scale) && $stable(res_limit)
                                 && $stable(res_integral))
    else $error("stalled result changed");

  // An upper clamp reports the configured upper bound.
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_limit == LIM_UPPER |-> res_scale == upper_q)
    else $error("upper clamp does not match the upper bound");

  // A lower clamp reports the configured lower bound.
  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_limit == LIM_LOWER |-> res_scale == lower_q)
    else $error("lower clamp does not match the lower bound");

  // Every result belongs to an accepted item, and no more than four are held.
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> inflight_q != 3'd0 && inflight_q <= 3'd4)
    else $error("result without a matching item in flight");

endmodule

bind pi_clock_servo_antiwindup_unit psaw_chk u_psaw_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid    (cfg_i.valid),
  .cfg_ready    (cfg_i.ready),
  .cfg_index    (cfg_i.index),
  .cfg_data     (cfg_i.data),
  .smp_valid    (smp_i.valid),
  .smp_ready    (smp_i.ready),
  .res_valid    (res_o.valid),
  .res_ready    (res_o.ready),
  .res_scale    (res_o.scale_ppb),
  .res_limit    (res_o.limit_hit),
  .res_integral (res_o.integral_ppb)
);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import psaw_pkg::*;

  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 140;

  // Operation code that the package leaves unnamed; the block must ignore it.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // Typical loop gains, 0.7 and 0.3 in the gain fixed-point format.
  localparam logic [31:0] TYP_KP = 32'd11744051;
  localparam logic [31:0] TYP_KI = 32'd5033165;

  logic clk_i;
  logic rst_ni;

  psaw_cfg_if cfg ();
  psaw_smp_if smp ();
  psaw_res_if res ();

  pi_clock_servo_antiwindup_unit #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .smp_i (smp),
    .res_o (res)
  );

  // One servo update as it should leave the block.
  typedef struct {
    logic signed [31:0] scale;
    limit_e             lim;
    logic signed [31:0] integ;
  } servo_update_t;

  // Servo state tracker and in-order comparison of result items.
  class servo_scoreboard;
    logic        [31:0] kp;
    logic        [31:0] ki;
    logic signed [31:0] upper;
    logic signed [31:0] lower;
    logic signed [63:0] integ_acc;
    logic signed [31:0] last_scale;
    servo_update_t      expected_q[$];
    int unsigned        failures;

    function new();
      kp         = '0;
      ki         = '0;
      upper      = UPPER_RESET;
      lower      = LOWER_RESET;
      integ_acc  = '0;
      last_scale = '0;
      failures   = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        REG_KP:    kp = data;
        REG_KI:    ki = data;
        REG_UPPER: upper = data;
        REG_LOWER: lower = data;
        default: ;
      endcase
    endfunction

    // Drop the fraction bits, rounding toward zero.
    function logic signed [66:0] drop_fraction(logic signed [66:0] v);
      logic signed [66:0] mag;
      mag = (v < 0) ? -v : v;
      mag = mag >> FRAC_BITS;
      return (v < 0) ? -mag : mag;
    endfunction

    // Advance the servo state by one accepted item and queue its result.
    function void note_item(logic [OP_W-1:0] op, logic signed [31:0] off);
      logic signed [63:0] p_term;
      logic signed [63:0] i_term;
      logic signed [66:0] total;
      logic signed [66:0] whole;
      logic signed [64:0] acc_sum;
      servo_update_t      r;
      r.lim = LIM_NONE;
      case (op)
        OP_SAMPLE: begin
          p_term = $signed({32'd0, kp}) * $signed(64'(off));
          i_term = $signed({32'd0, ki}) * $signed(64'(off));
          // The wide sum keeps its true sign even past 64 bits.
          total = 67'(p_term) + 67'(i_term) + 67'(integ_acc);
          whole = drop_fraction(total);
          if (whole > upper) begin
            last_scale = upper;
            r.lim = LIM_UPPER;
          end else if (whole < lower) begin
            last_scale = lower;
            r.lim = LIM_LOWER;
          end else begin
            last_scale = whole[31:0];
            // Anti-windup: integrate only when the output was not clamped.
            acc_sum = 65'(integ_acc) + 65'(i_term);
            if (acc_sum[64] != acc_sum[63]) begin
              integ_acc = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
              integ_acc = acc_sum[63:0];
            end
          end
        end
        OP_CLEAR: integ_acc = '0;
        OP_SEED:  integ_acc = 64'(last_scale) <<< FRAC_BITS;
        default: ;
      endcase
      r.scale = last_scale;
      whole = drop_fraction(67'(integ_acc));
      if (whole > 67'sh7FFF_FFFF) begin
        r.integ = 32'sh7FFF_FFFF;
      end else if (whole < -67'sh8000_0000) begin
        r.integ = 32'sh8000_0000;
      end else begin
        r.integ = whole[31:0];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] scale, logic [LIMIT_W-1:0] lim,
                               logic signed [31:0] integ);
      servo_update_t r;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: scale %0d limit %0d integral %0d", scale, lim, integ);
        end
        return;
      end
      r = expected_q.pop_front();
      if (scale !== r.scale || lim !== r.lim || integ !== r.integ) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected scale %0d limit %0d integral %0d, got %0d %0d %0d",
                   r.scale, r.lim, r.integ, scale, lim, integ);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  servo_scoreboard sb = new();

  int unsigned cycle_count;
  int          hold_cycles;
  int          run_left;
  int          stall_left;
  bit          calm;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Observe every handshake on the three channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        sb.write_reg(cfg_reg_e'(cfg.index), cfg.data);
      end
      if (res.valid && res.ready) begin
        sb.check_result(res.scale_ppb, res.limit_hit, res.integral_ppb);
      end
      if (smp.valid && smp.ready) begin
        sb.note_item(smp.op, smp.ofs_ns);
      end
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      res.ready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else begin
      res.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 20);
        stall_left = calm ? 0 : pick_gap();
      end
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic [OP_W-1:0] op, logic signed [31:0] off);
    smp.valid  <= 1'b1;
    smp.op     <= op;
    smp.ofs_ns <= off;
    do @(posedge clk_i); while (!smp.ready);
    @(negedge clk_i);
  endtask

  task automatic source_gap();
    int n;
    n = calm ? 0 : pick_gap();
    if (n > 0) begin
      smp.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_spaced(logic [OP_W-1:0] op, logic signed [31:0] off);
    send_item(op, off);
    source_gap();
  endtask

  // Stop offering and wait until every result is back.
  task automatic drain();
    smp.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] up,
                            logic [31:0] lo);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [OP_W-1:0] rand_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) return OP_SAMPLE;
    if (r < 89) return OP_CLEAR;
    if (r < 96) return OP_SEED;
    return OP_RESERVED;
  endfunction

  // Offsets spread over small, medium and full-range magnitudes.
  function automatic logic signed [31:0] rand_offset();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 4000)) - 2000;
      1: v = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      2: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // Stimulus.
  initial begin
    logic        [31:0] kp_v;
    logic        [31:0] ki_v;
    logic signed [31:0] up_v;
    logic signed [31:0] lo_v;
    smp.valid     = 1'b0;
    smp.op        = OP_SAMPLE;
    smp.ofs_ns    = '0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_KP;
    cfg.data      = '0;
    res.ready     = 1'b0;
    rst_ni        = 1'b0;
    hold_cycles   = 0;
    run_left      = 0;
    stall_left    = 0;
    calm          = 1'b0;
    cycle_count   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset gains give a zero output.
    send_spaced(OP_SAMPLE, 32'sd12345);
    drain();

    // Typical gains: in-bounds samples, both clamps, seed, clear, reserved op.
    set_config(TYP_KP, TYP_KI, 32'sd500000, -32'sd500000);
    send_spaced(OP_SAMPLE, 32'sd0);
    send_spaced(OP_SAMPLE, 32'sd1000);
    send_spaced(OP_SAMPLE, -32'sd1000);
    send_spaced(OP_SAMPLE, 32'sh7FFF_FFFF);
    send_spaced(OP_SAMPLE, 32'sh8000_0000);
    send_spaced(OP_SAMPLE, 32'sd37);
    send_spaced(OP_SEED, 32'sd0);
    send_spaced(OP_SAMPLE, 32'sd5);
    send_spaced(OP_CLEAR, 32'sd0);
    send_spaced(OP_RESERVED, $urandom);
    send_spaced(OP_SAMPLE, -32'sd1);
    drain();

    // Largest gains: sums beyond 64 bits must still clamp on their sign.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_spaced(OP_SAMPLE, 32'sh7FFF_FFFF);
    send_spaced(OP_SAMPLE, 32'sh8000_0000);
    send_spaced(OP_SAMPLE, 32'sd1);
    send_spaced(OP_SAMPLE, -32'sd1);
    send_spaced(OP_SEED, 32'sd0);
    drain();

    // Crossed bounds: the upper test wins.
    set_config(TYP_KP, TYP_KI, -32'sd1000, 32'sd1000);
    send_spaced(OP_CLEAR, 32'sd0);
    send_spaced(OP_SAMPLE, 32'sd0);
    send_spaced(OP_SAMPLE, -32'sd1000000);
    send_spaced(OP_SAMPLE, 32'sd20);
    drain();

    // Random phases, each with its own setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          kp_v = TYP_KP;
          ki_v = TYP_KI;
          up_v = 32'sd500000;
          lo_v = -32'sd500000;
        end
        1: begin
          kp_v = $urandom_range(0, 1 << 26);
          ki_v = $urandom_range(0, 1 << 24);
          up_v = $urandom_range(1, 1 << 30);
          lo_v = -int'($urandom_range(1, 1 << 30));
        end
        2: begin
          kp_v = '0;
          ki_v = 32'hFFFF_FFFF;
          up_v = 32'sh7FFF_FFFF;
          lo_v = 32'sh8000_0000;
        end
        3: begin
          kp_v = $urandom;
          ki_v = $urandom;
          up_v = $urandom;
          lo_v = $urandom;
        end
        4: begin
          // No gain at all and a single allowed output value.
          kp_v = '0;
          ki_v = '0;
          up_v = $urandom;
          lo_v = up_v;
        end
        default: begin
          kp_v = $urandom_range(1 << 20, 1 << 28);
          ki_v = $urandom_range(0, 1 << 22);
          up_v = 32'sh7FFF_FFFF;
          lo_v = 32'sh8000_0000;
        end
      endcase
      set_config(kp_v, ki_v, up_v, lo_v);
      calm = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Back-to-back items against a stalled receiver fill the pipeline.
        if (ph == 1 && n == 30) hold_cycles = 300;
        // Let the block run dry once in the middle of each phase.
        if (n == PHASE_ITEMS / 2) drain();
        send_spaced(rand_op(), rand_offset());
      end
      drain();
    end
    calm = 1'b0;

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
